FILE: sv/fmdd_pkg.sv
// Shared types and constants for the FM discriminator with de-emphasis.
`timescale 1ns / 1ps
package fmdd_pkg;

  // Divider datapath width: 32-bit numerator magnitude shifted up by the 12 fraction bits,
  // plus the 33-bit denominator shifted by the same amount.
  localparam int unsigned DIV_W = 45;
  localparam int unsigned QUO_W = 16;
  localparam int unsigned STEP_W = 5;

  // Phase scaling: pi/4 and 3*pi/4 with pi = 16384.
  localparam int unsigned PHASE_SHIFT = 12;
  localparam logic signed [15:0] PHASE_QUARTER_PI = 16'sd4096;
  localparam logic signed [15:0] PHASE_THREE_QUARTER_PI = 16'sd12288;

  // Quotient bits per division.
  localparam logic [STEP_W-1:0] PHASE_STEPS = 5'd13;
  localparam logic [STEP_W-1:0] AUDIO_STEPS = 5'd16;
  localparam int unsigned AUDIO_SHIFT = 15;

  // Configuration register indexes.
  localparam logic CFG_DEEMPH_DIVISOR = 1'b0;
  localparam logic CFG_DEEMPH_ENABLE = 1'b1;

  localparam logic [7:0] DEEMPH_DIVISOR_RESET = 8'd19;

  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] disc_value;
    logic signed [15:0] audio_value;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: sv/fmdd_div.sv
// Shared restoring divider: one quotient bit per cycle against a pre-shifted divisor.
`timescale 1ns / 1ps
module fmdd_div import fmdd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dsh_q, dsh_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [DIV_W:0]    diff;

  assign diff = {1'b0, rem_q} - {1'b0, dsh_q};

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      rem_d  = req_i.num;
      dsh_d  = req_i.den;
      quo_d  = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // subtract when the shifted divisor fits, then move it one bit down
      if (!diff[DIV_W]) begin
        rem_d = diff[DIV_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;

endmodule

FILE: sv/fm_discriminator_deemphasis.sv
// FM polar discriminator: sequenced multiplier, approximate atan2 and one-pole de-emphasis.
// Steps after accept: four products on the one 16x16 multiplier, a setup step and the
// phase division, a setup step and the de-emphasis division (skipped with de-emphasis
// off), then the load of the result word. Input is stalled until that load, so only
// one sample is in flight at a time.
// Reset clears the previous sample, the accumulator and the handshake state, and
// loads divisor 19 with de-emphasis enabled.
`timescale 1ns / 1ps
module fm_discriminator_deemphasis import fmdd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_PREP  = 7'b0000100,
    ST_PHASE = 7'b0001000,
    ST_FILT  = 7'b0010000,
    ST_ACC   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] cfg_div_q;
  logic       cfg_en_q;
  logic [7:0] div_eff;

  logic signed [15:0] smp_i_q, smp_q_q, prv_i_q, prv_q_q;
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod_q, prod_d;
  logic signed [32:0] re_q, re_d, im_q, im_d;
  logic [2:0]         mstep_q, mstep_d;

  logic zero_q, zero_d, xneg_q, xneg_d, yneg_q, yneg_d, nneg_q, nneg_d, dneg_q, dneg_d;
  logic signed [15:0] disc_q, disc_d, audio_q, audio_d, acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  // phase setup
  logic signed [33:0] re34, im34, ya34, num34, den34, nmag34;
  // phase finish
  logic signed [15:0] q16, sq16, base16, a16;
  // de-emphasis
  logic signed [16:0] d17, dmag17, q17, step17, acc17;
  logic [16:0]        nm17;

  div_req_t div_req;
  div_rsp_t div_rsp;

  fmdd_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign div_eff = (cfg_div_q == 8'd0) ? 8'd1 : cfg_div_q;

  // shared multiplier operand select
  always_comb begin
    unique case (mstep_q)
      3'd0:    begin mul_a = smp_i_q; mul_b = prv_i_q; end
      3'd1:    begin mul_a = smp_q_q; mul_b = prv_q_q; end
      3'd2:    begin mul_a = smp_q_q; mul_b = prv_i_q; end
      default: begin mul_a = smp_i_q; mul_b = prv_q_q; end
    endcase
  end

  always_comb begin
    re34   = {re_q[32], re_q};
    im34   = {im_q[32], im_q};
    ya34   = im_q[32] ? -im34 : im34;
    num34  = re_q[32] ? (re34 + ya34) : (re34 - ya34);
    den34  = re_q[32] ? (ya34 - re34) : (re34 + ya34);
    nmag34 = num34[33] ? -num34 : num34;

    q16    = {3'b000, div_rsp.quo[12:0]};
    sq16   = nneg_q ? -q16 : q16;
    base16 = xneg_q ? PHASE_THREE_QUARTER_PI : PHASE_QUARTER_PI;
    a16    = base16 - sq16;

    d17    = {disc_q[15], disc_q} - {acc_q[15], acc_q};
    dmag17 = d17[16] ? -d17 : d17;
    nm17   = dmag17 + {10'b0, div_eff[7:1]};

    q17    = {1'b0, div_rsp.quo};
    step17 = dneg_q ? -q17 : q17;
    acc17  = {acc_q[15], acc_q} + step17;
  end

  always_comb begin
    state_d     = state_q;
    mstep_d     = mstep_q;
    prod_d      = prod_q;
    re_d        = re_q;
    im_d        = im_q;
    zero_d      = zero_q;
    xneg_d      = xneg_q;
    yneg_d      = yneg_q;
    nneg_d      = nneg_q;
    dneg_d      = dneg_q;
    disc_d      = disc_q;
    audio_d     = audio_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    div_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        mstep_d = 3'd0;
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = mul_a * mul_b;
        mstep_d = mstep_q + 3'd1;
        unique case (mstep_q)
          3'd0: ;
          3'd1: re_d = 33'(prod_q);
          3'd2: re_d = re_q + 33'(prod_q);
          3'd3: im_d = 33'(prod_q);
          default: begin
            im_d    = im_q - 33'(prod_q);
            state_d = ST_PREP;
          end
        endcase
      end
      ST_PREP: begin
        zero_d        = (re_q == '0) && (im_q == '0);
        xneg_d        = re_q[32];
        yneg_d        = im_q[32];
        nneg_d        = num34[33];
        div_req.start = 1'b1;
        div_req.num   = {1'b0, nmag34[31:0], {PHASE_SHIFT{1'b0}}};
        div_req.den   = {den34[32:0], {PHASE_SHIFT{1'b0}}};
        div_req.steps = PHASE_STEPS;
        state_d       = ST_PHASE;
      end
      ST_PHASE: begin
        if (!div_rsp.busy) begin
          disc_d  = zero_q ? 16'sd0 : (yneg_q ? -a16 : a16);
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        if (cfg_en_q) begin
          dneg_d        = d17[16];
          div_req.start = 1'b1;
          div_req.num   = {28'b0, nm17};
          div_req.den   = {22'b0, div_eff, {AUDIO_SHIFT{1'b0}}};
          div_req.steps = AUDIO_STEPS;
          state_d       = ST_ACC;
        end else begin
          audio_d = disc_q;
          state_d = ST_OUT;
        end
      end
      ST_ACC: begin
        if (!div_rsp.busy) begin
          acc_d   = acc17[15:0];
          audio_d = acc17[15:0];
          state_d = ST_OUT;
        end
      end
      default: begin
        // hold the result until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.disc_value  = disc_q;
          out_d.audio_value = audio_q;
          state_d           = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mstep_q     <= '0;
      out_valid_q <= 1'b0;
      prv_i_q     <= '0;
      prv_q_q     <= '0;
      acc_q       <= '0;
      cfg_div_q   <= DEEMPH_DIVISOR_RESET;
      cfg_en_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      mstep_q     <= mstep_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      // the current sample becomes the previous one once all products are taken
      if (state_q == ST_MUL && mstep_q == 3'd4) begin
        prv_i_q <= smp_i_q;
        prv_q_q <= smp_q_q;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEEMPH_DIVISOR: cfg_div_q <= cfg_data_i;
          CFG_DEEMPH_ENABLE:  cfg_en_q  <= cfg_data_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      smp_i_q <= in_data_i.sample_i;
      smp_q_q <= in_data_i.sample_q;
    end
    prod_q  <= prod_d;
    re_q    <= re_d;
    im_q    <= im_d;
    zero_q  <= zero_d;
    xneg_q  <= xneg_d;
    yneg_q  <= yneg_d;
    nneg_q  <= nneg_d;
    dneg_q  <= dneg_d;
    disc_q  <= disc_d;
    audio_q <= audio_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: test/fm_discriminator_deemphasis_tb.sv
// Self-checking testbench for the FM discriminator with de-emphasis.
`timescale 1ns / 1ps
module fm_discriminator_deemphasis_tb;
  import fmdd_pkg::*;

  localparam longint PI_QUARTER = 4096;
  localparam longint PI_THREE_QUARTERS = 3 * 4096;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 45;
  localparam int unsigned NUM_STEPS = 9;

  // Tracks the discriminator and de-emphasis state and holds the words still owed.
  class fm_demod_scoreboard;
    logic [7:0] divisor = DEEMPH_DIVISOR_RESET;
    logic deemph_on = 1'b1;
    int prev_i;
    int prev_q;
    int audio_acc;
    out_item_t expected_words[$];
    int unsigned mismatches;

    function void write_register(logic idx, logic [7:0] data);
      if (idx == CFG_DEEMPH_DIVISOR) begin
        divisor = data;
      end else begin
        deemph_on = data[0];
      end
    endfunction

    // Approximate atan2 of (y, x), pi scaled to 16384.
    function int phase_diff(longint y, longint x);
      longint ya;
      longint a;
      if (x == 0 && y == 0) return 0;
      ya = (y < 0) ? -y : y;
      if (x >= 0) begin
        a = PI_QUARTER - (PI_QUARTER * (x - ya)) / (x + ya);
      end else begin
        a = PI_THREE_QUARTERS - (PI_QUARTER * (x + ya)) / (ya - x);
      end
      return int'((y < 0) ? -a : a);
    endfunction

    // Move the accumulator toward the new value, rounding the step to nearest, halves away from zero.
    function int deemph_step(int disc);
      int dv;
      int d;
      dv = (divisor == 8'd0) ? 1 : int'(divisor);
      d = disc - audio_acc;
      if (d > 0) begin
        audio_acc += (d + dv / 2) / dv;
      end else begin
        audio_acc += (d - dv / 2) / dv;
      end
      return audio_acc;
    endfunction

    function void accept_sample(in_item_t s);
      out_item_t w;
      longint ci;
      longint cq;
      longint re;
      longint im;
      int disc;
      int audio;
      ci = s.sample_i;
      cq = s.sample_q;
      re = ci * prev_i + cq * prev_q;
      im = cq * prev_i - ci * prev_q;
      disc = phase_diff(im, re);
      audio = deemph_on ? deemph_step(disc) : disc;
      prev_i = int'(s.sample_i);
      prev_q = int'(s.sample_q);
      w.disc_value = disc[15:0];
      w.audio_value = audio[15:0];
      expected_words.push_back(w);
    endfunction

    function void check_word(out_item_t w);
      out_item_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected word: disc_value %0d audio_value %0d",
               w.disc_value, w.audio_value);
        mismatches++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (w.disc_value !== exp_w.disc_value) begin
        $error("disc_value: expected %0d, got %0d", exp_w.disc_value, w.disc_value);
        mismatches++;
      end
      if (w.audio_value !== exp_w.audio_value) begin
        $error("audio_value: expected %0d, got %0d", exp_w.audio_value, w.audio_value);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = 8'd0;

  fm_demod_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned idle_max = 12;
  int unsigned long_hold_cycles = 0;

  fm_discriminator_deemphasis i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fm_discriminator_deemphasis regression: fail");
      $finish;
    end
  end

  // Offer one word after a random gap; return at the edge that accepts it.
  task automatic send_sample(input in_item_t s);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.accept_sample(s);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and hold until every owed word has come back.
  task automatic wait_drained(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Small random steps from the last sample, plus turns, corner cases and noise.
  function automatic in_item_t next_sample(input in_item_t p);
    in_item_t s;
    logic signed [15:0] corner_vals [5];
    corner_vals = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case ($urandom_range(0, 15))
      0, 1, 2: s = in_item_t'($urandom());
      3: s = p;
      4: begin
        s.sample_i = -p.sample_i;
        s.sample_q = -p.sample_q;
      end
      5: begin
        s.sample_i = -p.sample_q;
        s.sample_q = p.sample_i;
      end
      6: begin
        s.sample_i = p.sample_q;
        s.sample_q = -p.sample_i;
      end
      7: begin
        s.sample_i = corner_vals[$urandom_range(0, 4)];
        s.sample_q = corner_vals[$urandom_range(0, 4)];
      end
      8: begin
        s.sample_i = 16'(int'($urandom_range(0, 16)) - 8);
        s.sample_q = 16'(int'($urandom_range(0, 16)) - 8);
      end
      9: s = '0;
      default: begin
        s.sample_i = p.sample_i + 16'(int'($urandom_range(0, 1024)) - 512);
        s.sample_q = p.sample_q + 16'(int'($urandom_range(0, 1024)) - 512);
      end
    endcase
    return s;
  endfunction

  initial begin : result_side
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = $urandom_range(0, idle_max);
      if (long_hold_cycles != 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_word(out_data_o);
    end
  end

  initial begin : sample_side
    in_item_t directed [20];
    in_item_t last_word;
    int unsigned step_div [NUM_STEPS];
    int unsigned step_en [NUM_STEPS];
    int unsigned step_count [NUM_STEPS];
    int unsigned step_idle [NUM_STEPS];
    directed = '{
      '{16'sd0, 16'sd0},           // zero product right after reset
      '{16'sd32767, 16'sd0},       // previous sample still zero
      '{16'sd32767, 16'sd0},       // no rotation
      '{16'sh8000, 16'sd0},        // negative real axis
      '{16'sh8000, 16'sh8000},
      '{16'sh8000, 16'sh8000},     // largest real part
      '{16'sd32767, 16'sd32767},
      '{16'sh8000, 16'sd32767},
      '{16'sd0, 16'sh8000},
      '{16'sd1, 16'sd0},           // quarter turn up
      '{16'sd0, -16'sd1},          // quarter turn down
      '{16'sd1, -16'sd1},          // real part equals imaginary magnitude
      '{-16'sd1, -16'sd1},
      '{16'sd1, 16'sd1},           // half turn
      '{16'sd3, 16'sd4},
      '{-16'sd4, 16'sd3},
      '{-16'sd3, -16'sd4},
      '{16'sd0, 16'sd0},           // zero product after a live sample
      '{16'sd32767, 16'sh8000},
      '{16'sh8000, 16'sd32767}
    };
    step_div = '{1, 255, 0, 7, 128, 2, 255, 19, 3};
    step_en = '{1, 1, 1, 0, 1, 1, 0, 1, 1};
    step_count = '{150, 200, 120, 150, 180, 180, 120, 200, 150};
    step_idle = '{12, 12, 12, 12, 0, 12, 12, 12, 4};
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_sample(directed[k]);
    last_word = directed[19];

    for (int p = 0; p < NUM_STEPS; p++) begin
      wait_drained(4);
      idle_max = step_idle[p];
      write_reg(CFG_DEEMPH_DIVISOR, 8'(step_div[p]));
      // upper data bits are don't-care for the enable register
      write_reg(CFG_DEEMPH_ENABLE, {7'($urandom_range(0, 127)), step_en[p][0]});
      for (int n = 0; n < step_count[p]; n++) begin
        // stall the result side for a long stretch while samples keep coming
        if (p == 1 && n == 40) long_hold_cycles = 400;
        last_word = next_sample(last_word);
        send_sample(last_word);
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (sb.mismatches == 0) begin
      $display("fm_discriminator_deemphasis regression: pass");
    end else begin
      $display("fm_discriminator_deemphasis regression: fail");
    end
    $finish;
  end

endmodule
